/* src/cts_pkg.sv */
// ---------------------------------------------------------------------------
// cts_pkg
// Shared types, codes and constants of the task scheduler.
// ---------------------------------------------------------------------------
package cts_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int CNT_W = SLOT_W + 1;
	localparam int TIME_W = 18;
	localparam int SWC_W = 16;
	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [SWC_W-1:0] SWC_MAX = '1;

	localparam logic [1:0] MODE_RR = 2'd0;
	localparam logic [1:0] MODE_FCFS = 2'd1;

	localparam logic [0:0] CFG_MODE = 1'd0;
	localparam logic [0:0] CFG_QUANTUM = 1'd1;

	localparam logic [7:0] QUANTUM_RST = 8'd2;

	typedef enum logic [1:0] {
		ST_NEW,
		ST_READY,
		ST_RUNNING,
		ST_DONE
	} stat_t;

	typedef enum logic [1:0] {
		SC_NONE,
		SC_ADMIT,
		SC_FCFS,
		SC_PRIO
	} scan_op_t;

	typedef enum logic [2:0] {
		K_LOADED = 3'd0,
		K_FULL   = 3'd1,
		K_IDLE   = 3'd2,
		K_DISP   = 3'd3,
		K_DONE   = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADM0,
		S_POP,
		S_RR_DISP,
		S_RR_TICK,
		S_RR_ADM,
		S_RR_END,
		S_FC_SCAN,
		S_FC_DISP,
		S_FC_RUN,
		S_PR_SCAN,
		S_PR_DISP,
		S_PR_TICK,
		S_FIN,
		S_RES
	} state_t;

	typedef struct packed {
		logic [31:0] pid;
		logic [15:0] arr;
		logic [11:0] burst;
		logic [7:0]  prio;
	} rec_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic              load;
		rec_t              rec;
		logic [SLOT_W-1:0] sel_slot;
		logic [CNT_W-1:0]  loaded;
		logic [TIME_W-1:0] now;
		scan_op_t          op;
		logic              inc_ready;
		logic              inc_prio;
		logic              disp;
		logic              fcfs_wait;
		logic              set_stat;
		stat_t             new_stat;
		logic              dec_rem;
		logic              clr_rem;
	} ctl_t;

	typedef struct packed {
		logic [31:0]       pid;
		logic [15:0]       arr;
		logic [11:0]       rem;
		logic [TIME_W-1:0] wait_t;
		logic [TIME_W-1:0] resp;
		stat_t             stat;
	} view_t;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] slot;
		logic [15:0]       key;
	} cand_t;

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       pid;
		logic              switched;
		logic [11:0]       run;
		logic              finished;
		logic [TIME_W-1:0] ta;
		logic [TIME_W-1:0] wait_t;
		logic [TIME_W-1:0] resp;
	} res_t;

endpackage

/* src/cts_item_if.sv */
// ---------------------------------------------------------------------------
// cts_item_if
// Request channel into the scheduler: a load record or a step request.
// ---------------------------------------------------------------------------
interface cts_item_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] proc_id;
	logic [15:0] arrival_time;
	logic [11:0] burst_time;
	logic [7:0]  prio_level;

	modport source (output valid, action, proc_id, arrival_time, burst_time, prio_level,
		input ready);
	modport sink (input valid, action, proc_id, arrival_time, burst_time, prio_level,
		output ready);
endinterface

/* src/cts_result_if.sv */
// ---------------------------------------------------------------------------
// cts_result_if
// Result channel out of the scheduler, one result per request.
// ---------------------------------------------------------------------------
interface cts_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [3:0]  slot;
	logic [31:0] out_proc_id;
	logic        switched;
	logic [17:0] time_now;
	logic [11:0] run_length;
	logic        finished;
	logic [17:0] turnaround;
	logic [17:0] wait_total;
	logic [17:0] response;
	logic [15:0] switch_count;

	modport source (output valid, kind, slot, out_proc_id, switched, time_now, run_length,
		finished, turnaround, wait_total, response, switch_count, input ready);
	modport sink (input valid, kind, slot, out_proc_id, switched, time_now, run_length,
		finished, turnaround, wait_total, response, switch_count, output ready);
endinterface

/* src/cts_cell.sv */
// ---------------------------------------------------------------------------
// cts_cell
// One process slot: holds its record and timing state, takes the scan
// token and the best candidate from its left neighbor and hands them on.
// ---------------------------------------------------------------------------
module cts_cell import cts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] idx,
	input  ctl_t              ctl,
	input  logic              tok_in,
	input  cand_t             cand_in,
	output logic              tok_out,
	output cand_t             cand_out,
	output view_t             view,
	output logic              push
);

	logic              tok_q;
	cand_t             cand_q;
	logic [31:0]       pid_q;
	logic [15:0]       arr_q;
	logic [11:0]       rem_q;
	logic [7:0]        prio_q;
	logic [TIME_W-1:0] wait_q;
	logic [TIME_W-1:0] resp_q;
	logic              rset_q;
	stat_t             stat_q;

	logic              used, sel, arrived, live, active, elig, take, wait_inc;
	logic [15:0]       key;
	logic [TIME_W-1:0] since;

	always_comb begin
		used     = {1'b0, idx} < ctl.loaded;
		sel      = idx == ctl.sel_slot;
		arrived  = {2'b00, arr_q} <= ctl.now;
		live     = stat_q != ST_DONE;
		active   = tok_q && used;
		push     = active && ctl.op == SC_ADMIT && stat_q == ST_NEW && arrived;
		elig     = (ctl.op == SC_FCFS) ? live : (arrived && rem_q != '0 && live);
		key      = (ctl.op == SC_FCFS) ? arr_q : {8'd0, prio_q};
		take     = active && (ctl.op == SC_FCFS || ctl.op == SC_PRIO) && elig &&
			(!cand_in.valid || key < cand_in.key);
		since    = ctl.now - {2'b00, arr_q};
		wait_inc = used && ((ctl.inc_ready && stat_q == ST_READY) ||
			(ctl.inc_prio && !sel && arrived && rem_q != '0 && live));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			cand_q <= '0;
		end else begin
			tok_q <= tok_in;
			if (tok_q) begin
				cand_q <= take ? '{valid: 1'b1, slot: idx, key: key} : cand_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && sel) begin
			pid_q  <= ctl.rec.pid;
			arr_q  <= ctl.rec.arr;
			rem_q  <= ctl.rec.burst;
			prio_q <= ctl.rec.prio;
			wait_q <= '0;
			resp_q <= '0;
			rset_q <= 1'b0;
			stat_q <= ST_NEW;
		end else begin
			if (push) begin
				stat_q <= ST_READY;
			end
			if (ctl.set_stat && sel) begin
				stat_q <= ctl.new_stat;
			end
			if (wait_inc && wait_q != TIME_MAX) begin
				wait_q <= wait_q + 1'b1;
			end
			if (ctl.fcfs_wait && sel) begin
				wait_q <= since;
			end
			if (ctl.disp && sel && !rset_q) begin
				resp_q <= since;
				rset_q <= 1'b1;
			end
			if (ctl.dec_rem && sel) begin
				rem_q <= rem_q - 1'b1;
			end
			if (ctl.clr_rem && sel) begin
				rem_q <= '0;
			end
		end
	end

	assign tok_out  = tok_q;
	assign cand_out = cand_q;
	assign view     = '{pid: pid_q, arr: arr_q, rem: rem_q, wait_t: wait_q, resp: resp_q,
		stat: stat_q};

endmodule

/* src/cts_row.sv */
// ---------------------------------------------------------------------------
// cts_row
// The chain of slot cells; a scan token enters at slot 0 and walks one
// slot per cycle, the winning candidate leaves the last cell.
// ---------------------------------------------------------------------------
module cts_row import cts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  ctl_t  ctl,
	input  logic  start,
	output view_t views [NUM_SLOTS],
	output logic  push_any,
	output cand_t cand_last
);

	logic  tok  [NUM_SLOTS+1];
	cand_t cand [NUM_SLOTS+1];
	logic  [NUM_SLOTS-1:0] push;

	assign tok[0]  = start;
	assign cand[0] = '0;

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		cts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (SLOT_W'(i)),
			.ctl      (ctl),
			.tok_in   (tok[i]),
			.cand_in  (cand[i]),
			.tok_out  (tok[i+1]),
			.cand_out (cand[i+1]),
			.view     (views[i]),
			.push     (push[i])
		);
	end

	assign push_any  = |push;
	assign cand_last = cand[NUM_SLOTS];

endmodule

/* src/cts_fifo.sv */
// ---------------------------------------------------------------------------
// cts_fifo
// Round robin ready queue of slot numbers.
// ---------------------------------------------------------------------------
module cts_fifo import cts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [SLOT_W-1:0] push_data,
	input  logic              pop,
	output logic [SLOT_W-1:0] head_data,
	output logic              empty
);

	logic [SLOT_W-1:0] mem [NUM_SLOTS];
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;
	logic [SLOT_W-1:0] wr_addr;

	always_comb begin
		do_pop  = pop && count_q != '0;
		do_push = push && count_q != CNT_W'(NUM_SLOTS);
		wr_addr = head_q + count_q[SLOT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_addr] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_pop) begin
				head_q <= head_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	assign head_data = mem[head_q];
	assign empty     = count_q == '0;

endmodule

/* src/cpu_task_scheduler.sv */
// ---------------------------------------------------------------------------
// cpu_task_scheduler
// Process table with round robin, first come first served and priority
// scheduling; one result per request.
// ---------------------------------------------------------------------------
// item channel takes a load record (action 0) or a step request (action 1);
// result channel returns one result per request, held in an output register.
// cfg_write/cfg_index/cfg_data set mode and quantum; the user must write them
// only while nothing is pending, the block itself does not enforce this.
// a step walks the 16-slot cell chain, one slot per cycle; in round robin
// the chain is walked again after every tick of a run.
// a new request is taken once the previous result sits in the output
// register; if the receiver stalls, the next result waits until it is taken.
// reset empties the table, the ready queue and all counters, mode is round
// robin and quantum is 2.
// ---------------------------------------------------------------------------
module cpu_task_scheduler import cts_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_write,
	input  logic [0:0]   cfg_index,
	input  logic [7:0]   cfg_data,
	cts_item_if.sink     item,
	cts_result_if.source result
);

	state_t            state_q, state_d;
	logic [1:0]        mode_q;
	logic [7:0]        quantum_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [TIME_W-1:0] time_q, time_d;
	logic [7:0]        left_q, left_d;
	logic [SLOT_W-1:0] sel_q, sel_d;
	logic              rv_q, rv_d;
	logic [SLOT_W-1:0] rs_q, rs_d;
	logic [SWC_W-1:0]  swc_q, swc_d;
	logic [CNT_W-1:0]  loaded_q, loaded_d;
	logic [CNT_W-1:0]  done_q, done_d;
	res_t              res_q, res_d;
	logic              out_v_q;
	res_t              out_q;
	logic [TIME_W-1:0] out_time_q;
	logic [SWC_W-1:0]  out_swc_q;

	ctl_t              ctl;
	logic              start;
	view_t             views [NUM_SLOTS];
	view_t             v;
	logic              push_any;
	cand_t             cand_last;
	logic              fifo_push, fifo_pop, fifo_empty;
	logic [SLOT_W-1:0] fifo_head, push_data, rd_slot;

	logic              accept, scan_end, sw, out_free;
	logic [TIME_W-1:0] tick_t, ta;
	logic [7:0]        q_eff;
	logic [TIME_W:0]   sum;

	cts_row u_row (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.start     (start),
		.views     (views),
		.push_any  (push_any),
		.cand_last (cand_last)
	);

	cts_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.push_data (push_data),
		.pop       (fifo_pop),
		.head_data (fifo_head),
		.empty     (fifo_empty)
	);

	assign item.ready = state_q == S_IDLE;
	assign accept     = item.valid && item.ready;
	assign out_free   = !out_v_q || result.ready;

	always_comb begin
		rd_slot  = (state_q == S_POP) ? fifo_head : sel_q;
		v        = views[rd_slot];
		scan_end = cnt_q == CNT_W'(NUM_SLOTS);
		tick_t   = (time_q == TIME_MAX) ? time_q : time_q + 1'b1;
		ta       = time_q - {2'b00, v.arr};
		q_eff    = (quantum_q == '0) ? 8'd1 : quantum_q;
		sum      = {1'b0, time_q} + (TIME_W+1)'(v.rem);
		sw       = !rv_q || rs_q != sel_q;
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		time_d   = time_q;
		left_d   = left_q;
		sel_d    = sel_q;
		rv_d     = rv_q;
		rs_d     = rs_q;
		swc_d    = swc_q;
		loaded_d = loaded_q;
		done_d   = done_q;
		res_d    = res_q;
		start    = 1'b0;
		fifo_pop = 1'b0;
		fifo_push = push_any;
		push_data = push_any ? cnt_q[SLOT_W-1:0] : sel_q;

		ctl           = '0;
		ctl.rec       = '{pid: item.proc_id, arr: item.arrival_time,
			burst: item.burst_time, prio: item.prio_level};
		ctl.sel_slot  = (state_q == S_IDLE) ? loaded_q[SLOT_W-1:0] : rd_slot;
		ctl.loaded    = loaded_q;
		ctl.now       = time_q;
		ctl.new_stat  = ST_NEW;

		case (state_q)
			S_ADM0, S_RR_ADM: ctl.op = SC_ADMIT;
			S_FC_SCAN:        ctl.op = SC_FCFS;
			S_PR_SCAN:        ctl.op = SC_PRIO;
			default:          ctl.op = SC_NONE;
		endcase

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_d = '0;
					cnt_d = '0;
					if (!item.action) begin
						state_d = S_RES;
						if (loaded_q == CNT_W'(NUM_SLOTS) || item.burst_time == '0) begin
							res_d.kind = K_FULL;
						end else begin
							ctl.load   = 1'b1;
							res_d.kind = K_LOADED;
							res_d.slot = loaded_q[SLOT_W-1:0];
							loaded_d   = loaded_q + 1'b1;
						end
					end else begin
						start = 1'b1;
						if (mode_q == MODE_RR) begin
							state_d = S_ADM0;
						end else if (mode_q == MODE_FCFS) begin
							state_d = S_FC_SCAN;
						end else begin
							state_d = S_PR_SCAN;
						end
					end
				end
			end
			S_ADM0: begin
				cnt_d = cnt_q + 1'b1;
				if (scan_end) begin
					state_d = S_POP;
				end
			end
			S_POP: begin
				if (fifo_empty) begin
					state_d = S_RES;
					if (done_q >= loaded_q) begin
						res_d.kind = K_DONE;
					end else begin
						time_d     = tick_t;
						res_d.kind = K_IDLE;
					end
				end else begin
					fifo_pop = 1'b1;
					// stale entries of finished slots are dropped
					if ({1'b0, fifo_head} < loaded_q && v.stat == ST_READY) begin
						sel_d   = fifo_head;
						state_d = S_RR_DISP;
					end
				end
			end
			S_RR_DISP: begin
				if (sw && swc_q != SWC_MAX) begin
					swc_d = swc_q + 1'b1;
				end
				rv_d           = 1'b1;
				rs_d           = sel_q;
				ctl.disp       = 1'b1;
				ctl.set_stat   = 1'b1;
				ctl.new_stat   = ST_RUNNING;
				left_d         = (v.rem < {4'd0, q_eff}) ? v.rem[7:0] : q_eff;
				res_d.kind     = K_DISP;
				res_d.slot     = sel_q;
				res_d.pid      = v.pid;
				res_d.switched = sw;
				res_d.run      = {4'd0, left_d};
				state_d        = S_RR_TICK;
			end
			S_RR_TICK: begin
				time_d        = tick_t;
				ctl.dec_rem   = 1'b1;
				ctl.inc_ready = 1'b1;
				left_d        = left_q - 1'b1;
				start         = 1'b1;
				cnt_d         = '0;
				state_d       = S_RR_ADM;
			end
			S_RR_ADM: begin
				cnt_d = cnt_q + 1'b1;
				if (scan_end) begin
					state_d = (left_q == '0) ? S_RR_END : S_RR_TICK;
				end
			end
			S_RR_END: begin
				state_d      = S_RES;
				ctl.set_stat = 1'b1;
				if (v.rem == '0) begin
					ctl.new_stat   = ST_DONE;
					done_d         = done_q + 1'b1;
					res_d.finished = 1'b1;
					res_d.ta       = ta;
					res_d.wait_t   = v.wait_t;
					res_d.resp     = v.resp;
				end else begin
					ctl.new_stat = ST_READY;
					fifo_push    = 1'b1;
				end
			end
			S_FC_SCAN, S_PR_SCAN: begin
				cnt_d = cnt_q + 1'b1;
				if (scan_end) begin
					if (cand_last.valid) begin
						sel_d   = cand_last.slot;
						state_d = (state_q == S_FC_SCAN) ? S_FC_DISP : S_PR_DISP;
					end else begin
						state_d = S_RES;
						if (state_q == S_PR_SCAN && done_q < loaded_q) begin
							time_d     = tick_t;
							res_d.kind = K_IDLE;
						end else begin
							res_d.kind = K_DONE;
						end
					end
				end
			end
			S_FC_DISP: begin
				if (time_q < {2'b00, v.arr}) begin
					time_d = {2'b00, v.arr};
				end
				state_d = S_FC_RUN;
			end
			S_FC_RUN: begin
				if (swc_q != SWC_MAX) begin
					swc_d = swc_q + 1'b1;
				end
				rv_d           = 1'b1;
				rs_d           = sel_q;
				ctl.disp       = 1'b1;
				ctl.fcfs_wait  = 1'b1;
				ctl.clr_rem    = 1'b1;
				time_d         = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
				res_d.kind     = K_DISP;
				res_d.slot     = sel_q;
				res_d.pid      = v.pid;
				res_d.switched = 1'b1;
				res_d.run      = v.rem;
				state_d        = S_FIN;
			end
			S_PR_DISP: begin
				if (sw && swc_q != SWC_MAX) begin
					swc_d = swc_q + 1'b1;
				end
				rv_d           = 1'b1;
				rs_d           = sel_q;
				ctl.disp       = 1'b1;
				ctl.inc_prio   = 1'b1;
				res_d.kind     = K_DISP;
				res_d.slot     = sel_q;
				res_d.pid      = v.pid;
				res_d.switched = sw;
				res_d.run      = 12'd1;
				state_d        = S_PR_TICK;
			end
			S_PR_TICK: begin
				time_d      = tick_t;
				ctl.dec_rem = 1'b1;
				state_d     = S_FIN;
			end
			S_FIN: begin
				state_d = S_RES;
				if (v.rem == '0) begin
					ctl.set_stat   = 1'b1;
					ctl.new_stat   = ST_DONE;
					done_d         = done_q + 1'b1;
					res_d.finished = 1'b1;
					res_d.ta       = ta;
					res_d.wait_t   = v.wait_t;
					res_d.resp     = v.resp;
				end
			end
			S_RES: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
		end else begin
			state_q   <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RR;
			quantum_q <= QUANTUM_RST;
			cnt_q     <= '0;
			time_q    <= '0;
			left_q    <= '0;
			sel_q     <= '0;
			rv_q      <= 1'b0;
			rs_q      <= '0;
			swc_q     <= '0;
			loaded_q  <= '0;
			done_q    <= '0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_MODE:    mode_q    <= cfg_data[1:0];
					CFG_QUANTUM: quantum_q <= cfg_data;
					default:     mode_q    <= mode_q;
				endcase
			end
			cnt_q    <= cnt_d;
			time_q   <= time_d;
			left_q   <= left_d;
			sel_q    <= sel_d;
			rv_q     <= rv_d;
			rs_q     <= rs_d;
			swc_q    <= swc_d;
			loaded_q <= loaded_d;
			done_q   <= done_d;
			if (state_q == S_RES && out_free) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (state_q == S_RES && out_free) begin
			out_q      <= res_q;
			out_time_q <= time_q;
			out_swc_q  <= swc_q;
		end
	end

	assign result.valid        = out_v_q;
	assign result.kind         = out_q.kind;
	assign result.slot         = out_q.slot;
	assign result.out_proc_id  = out_q.pid;
	assign result.switched     = out_q.switched;
	assign result.time_now     = out_time_q;
	assign result.run_length   = out_q.run;
	assign result.finished     = out_q.finished;
	assign result.turnaround   = out_q.ta;
	assign result.wait_total   = out_q.wait_t;
	assign result.response     = out_q.resp;
	assign result.switch_count = out_swc_q;

endmodule
